// ===== sv/gia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gia_pkg
// Shared constants and types for the complex integer ALU.
// ----------------------------------------------------------------------------
package gia_pkg;
   localparam int OperandWidth = 16;
   localparam int ResWidth     = 34;
   localparam int ProdWidth    = 2 * OperandWidth;
   localparam int NumWidth     = ProdWidth + 1;
   localparam int DenWidth     = ProdWidth + 1;
   localparam int QuoWidth     = NumWidth;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef struct packed {
      action_type                     action;
      logic signed [NumWidth-1:0]     val_re;
      logic signed [NumWidth-1:0]     val_im;
      logic        [DenWidth-1:0]     den;
   } stage_type;
endpackage
`default_nettype wire

// ===== sv/gia_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gia_front
// Two-stage product and sum unit: products, then combined numerators.
// ----------------------------------------------------------------------------
module gia_front (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    adv,
   input  wire                                    in_valid,
   input  wire [1:0]                              in_action,
   input  wire signed [gia_pkg::OperandWidth-1:0] a_re,
   input  wire signed [gia_pkg::OperandWidth-1:0] a_im,
   input  wire signed [gia_pkg::OperandWidth-1:0] b_re,
   input  wire signed [gia_pkg::OperandWidth-1:0] b_im,
   output logic                                   out_valid,
   output gia_pkg::stage_type                     out_data
);
   localparam int PW = gia_pkg::ProdWidth;
   localparam int NW = gia_pkg::NumWidth;

   logic                 v1_ff;
   gia_pkg::action_type  act1_ff;
   logic signed [PW-1:0] pac_ff, pbd_ff, pad_ff, pbc_ff, pcc_ff, pdd_ff;
   logic signed [NW-1:0] sre_ff, sim_ff;
   logic                 v2_ff;
   gia_pkg::stage_type   d2_in, d2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act1_ff <= gia_pkg::action_type'(in_action);
         pac_ff  <= a_re * b_re;
         pbd_ff  <= a_im * b_im;
         pad_ff  <= a_re * b_im;
         pbc_ff  <= a_im * b_re;
         pcc_ff  <= b_re * b_re;
         pdd_ff  <= b_im * b_im;
         case (gia_pkg::action_type'(in_action))
            gia_pkg::ACT_ADD: begin
               sre_ff <= NW'(a_re) + NW'(b_re);
               sim_ff <= NW'(a_im) + NW'(b_im);
            end
            default: begin
               sre_ff <= NW'(a_re) - NW'(b_re);
               sim_ff <= NW'(a_im) - NW'(b_im);
            end
         endcase
         d2_ff <= d2_in;
      end
   end

   always_comb begin
      d2_in.action = act1_ff;
      d2_in.den    = gia_pkg::DenWidth'($unsigned(pcc_ff)) +
                     gia_pkg::DenWidth'($unsigned(pdd_ff));
      case (act1_ff)
         gia_pkg::ACT_MUL: begin
            d2_in.val_re = NW'(pac_ff) - NW'(pbd_ff);
            d2_in.val_im = NW'(pad_ff) + NW'(pbc_ff);
         end
         gia_pkg::ACT_DIV: begin
            d2_in.val_re = NW'(pac_ff) + NW'(pbd_ff);
            d2_in.val_im = NW'(pbc_ff) - NW'(pad_ff);
         end
         default: begin
            d2_in.val_re = sre_ff;
            d2_in.val_im = sim_ff;
         end
      endcase
   end

   assign out_valid = v2_ff;
   assign out_data  = d2_ff;
endmodule
`default_nettype wire

// ===== sv/gia_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gia_divider
// Pipelined restoring divider, one quotient bit per stage for both parts.
// Signs are removed at entry and restored at exit (truncation toward zero).
// ----------------------------------------------------------------------------
module gia_divider (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  adv,
   input  wire                                  in_valid,
   input  gia_pkg::stage_type                   in_data,
   output logic                                 out_valid,
   output logic signed [gia_pkg::ResWidth-1:0]  res_re,
   output logic signed [gia_pkg::ResWidth-1:0]  res_im,
   output logic                                 div_zero
);
   localparam int QW = gia_pkg::QuoWidth;
   localparam int DW = gia_pkg::DenWidth;
   localparam int NS = QW + 1;

   // stage 0 = sign strip; stages 1..QW = bit steps
   logic              v_ff   [NS];
   logic              div_ff [NS];
   logic              nr_ff  [NS];
   logic              ni_ff  [NS];
   logic [DW-1:0]     den_ff [NS];
   logic [QW-1:0]     qr_ff  [NS];
   logic [QW-1:0]     qi_ff  [NS];
   logic [DW:0]       rr_ff  [NS];
   logic [DW:0]       ri_ff  [NS];
   logic [QW-1:0]     pr_ff  [NS];
   logic [QW-1:0]     pi_ff  [NS];

   logic              vo_ff, dz_ff;
   logic [gia_pkg::ResWidth-1:0] ore_ff, oim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) v_ff[s] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
         for (int s = 1; s < NS; s++) v_ff[s] <= v_ff[s-1];
         vo_ff <= v_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_ff[0] <= (in_data.action == gia_pkg::ACT_DIV);
         nr_ff[0]  <= in_data.val_re[QW-1];
         ni_ff[0]  <= in_data.val_im[QW-1];
         den_ff[0] <= in_data.den;
         pr_ff[0]  <= in_data.val_re;
         pi_ff[0]  <= in_data.val_im;
         qr_ff[0]  <= in_data.val_re[QW-1] ? QW'(-in_data.val_re) : in_data.val_re;
         qi_ff[0]  <= in_data.val_im[QW-1] ? QW'(-in_data.val_im) : in_data.val_im;
         rr_ff[0]  <= '0;
         ri_ff[0]  <= '0;
         for (int s = 1; s < NS; s++) begin
            logic [DW:0] tr, ti;
            tr = {rr_ff[s-1][DW-1:0], qr_ff[s-1][QW-1]};
            ti = {ri_ff[s-1][DW-1:0], qi_ff[s-1][QW-1]};
            div_ff[s] <= div_ff[s-1];
            nr_ff[s]  <= nr_ff[s-1];
            ni_ff[s]  <= ni_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            pr_ff[s]  <= pr_ff[s-1];
            pi_ff[s]  <= pi_ff[s-1];
            if (tr >= {1'b0, den_ff[s-1]}) begin
               rr_ff[s] <= tr - {1'b0, den_ff[s-1]};
               qr_ff[s] <= {qr_ff[s-1][QW-2:0], 1'b1};
            end else begin
               rr_ff[s] <= tr;
               qr_ff[s] <= {qr_ff[s-1][QW-2:0], 1'b0};
            end
            if (ti >= {1'b0, den_ff[s-1]}) begin
               ri_ff[s] <= ti - {1'b0, den_ff[s-1]};
               qi_ff[s] <= {qi_ff[s-1][QW-2:0], 1'b1};
            end else begin
               ri_ff[s] <= ti;
               qi_ff[s] <= {qi_ff[s-1][QW-2:0], 1'b0};
            end
         end
         if (!div_ff[NS-1]) begin
            ore_ff <= gia_pkg::ResWidth'($signed(pr_ff[NS-1]));
            oim_ff <= gia_pkg::ResWidth'($signed(pi_ff[NS-1]));
            dz_ff  <= 1'b0;
         end else if (den_ff[NS-1] == '0) begin
            ore_ff <= '0;
            oim_ff <= '0;
            dz_ff  <= 1'b1;
         end else begin
            ore_ff <= gia_pkg::ResWidth'($signed(nr_ff[NS-1] ? -qr_ff[NS-1] : qr_ff[NS-1]));
            oim_ff <= gia_pkg::ResWidth'($signed(ni_ff[NS-1] ? -qi_ff[NS-1] : qi_ff[NS-1]));
            dz_ff  <= 1'b0;
         end
      end
   end

   assign out_valid = vo_ff;
   assign res_re    = ore_ff;
   assign res_im    = oim_ff;
   assign div_zero  = dz_ff;
endmodule
`default_nettype wire

// ===== sv/gaussian_integer_alu_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_integer_alu_top
// Complex integer add, subtract, multiply and divide on a stream.
// ----------------------------------------------------------------------------
// One transaction in per cycle while the output is not stalled, one result per
// transaction, in order. The path is two product/sum stages, a sign stage, one
// stage per quotient bit of the 33-bit numerators, and an output register;
// every action walks the same pipeline. The whole pipeline advances when the
// output register is empty or taken, so a stall freezes it without loss.
module gaussian_integer_alu_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,  // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48]
   input  wire  [1:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [71:0] rsp_tdata,  // res_re[33:0], res_im[67:34], zero fill
   output logic        rsp_tuser   // div_zero
);
   localparam int OW = gia_pkg::OperandWidth;

   logic               adv;
   logic               f_valid, o_valid;
   gia_pkg::stage_type f_data;
   logic signed [gia_pkg::ResWidth-1:0] r_re, r_im;
   logic               dz;

   assign adv        = !o_valid || rsp_tready;
   assign req_tready = adv;

   gia_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_action (req_tuser),
      .a_re      (req_tdata[OW-1:0]),
      .a_im      (req_tdata[16+OW-1:16]),
      .b_re      (req_tdata[32+OW-1:32]),
      .b_im      (req_tdata[48+OW-1:48]),
      .out_valid (f_valid),
      .out_data  (f_data)
   );

   gia_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_data   (f_data),
      .out_valid (o_valid),
      .res_re    (r_re),
      .res_im    (r_im),
      .div_zero  (dz)
   );

   assign rsp_tvalid = o_valid;
   assign rsp_tdata  = {4'b0, r_im, r_re};
   assign rsp_tuser  = dz;
endmodule
`default_nettype wire

// ===== sv/gia_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gia_checker
// Port-level checks for the complex integer ALU.
// ----------------------------------------------------------------------------
module gia_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [71:0] rsp_tdata,
   input wire        rsp_tuser
);
   a_zero_res: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0) else $error("div_zero with data");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:68] == 4'b0) else $error("fill bits set");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("stalled while output empty");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule

bind gaussian_integer_alu_top gia_checker u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);
`default_nettype wire
